// File: rtl/core/assert_macros.svh
// assert_macros.svh: assertion shorthands for the move parser RTL.
// Relies on clk and rst_n being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define GMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define GMP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/gmp_pkg.sv
// gmp_pkg: constants, beat types and helper functions of the G0/G1 move parser.
// No dependencies; RTL files but gmp_char_if and the macros use scoped names.
package gmp_pkg;

    // Fixed-point configuration
    localparam int FRAC_DIGITS = 3;
    localparam int VALUE_BITS  = 32;
    localparam int POS_W       = 32;
    localparam int ACC_W       = VALUE_BITS;
    localparam int FRAC_W      = (FRAC_DIGITS < 2) ? 1 : $clog2(FRAC_DIGITS + 1);
    localparam int EXP_W       = $clog2(FRAC_DIGITS + 2);
    localparam int MUL_W       = $clog2(10 ** (FRAC_DIGITS + 1) + 1);

    // Magnitude cap 2^(VALUE_BITS-1) and its split by ten for digit saturation
    localparam logic [ACC_W-1:0] MAG_CAP   = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic [ACC_W-1:0] CAP_DIV10 = MAG_CAP / 10;
    localparam logic [3:0]       CAP_MOD10 = 4'(MAG_CAP % 10);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Axis codes
    localparam logic [2:0] AX_X    = 3'd0;
    localparam logic [2:0] AX_Y    = 3'd1;
    localparam logic [2:0] AX_Z    = 3'd2;
    localparam logic [2:0] AX_E    = 3'd3;
    localparam logic [2:0] AX_NONE = 3'd4;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_file;
    } char_beat_t;

    typedef struct packed {
        logic            valid;
        char_beat_t      beat;
    } held_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] pos_e;
    } pos_beat_t;

    // 10^e for e up to FRAC_DIGITS+1; folds to a small constant mux
    function automatic logic [MUL_W-1:0] pow10(input logic [EXP_W-1:0] e);
        logic [MUL_W-1:0] p;
        p = MUL_W'(1);
        for (int i = 0; i < FRAC_DIGITS + 1; i++) begin
            if (EXP_W'(i) < e) begin
                p = MUL_W'(p * 10);
            end
        end
        return p;
    endfunction

    // Low POS_W bits of the sign-extended value
    function automatic logic signed [POS_W-1:0] to_pos(input value_t v);
        logic signed [VALUE_BITS+POS_W-1:0] wide;
        wide = (VALUE_BITS + POS_W)'(v);
        return wide[POS_W-1:0];
    endfunction

endpackage

// File: rtl/core/gmp_char_if.sv
// gmp_char_if: valid/ready channel carrying one text character per beat.
// Uses gmp_pkg for nothing but keeps the same field names as the port list.
interface gmp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_file;

    modport source (output valid, output char_byte, output end_of_file, input ready);
    modport sink   (input valid, input char_byte, input end_of_file, output ready);
endinterface

// File: rtl/core/gmp_pos_if.sv
// gmp_pos_if: valid/ready channel carrying one four-axis position per beat.
// Field widths follow gmp_pkg::POS_W.
interface gmp_pos_if;
    logic                             valid;
    logic                             ready;
    logic signed [gmp_pkg::POS_W-1:0] pos_x;
    logic signed [gmp_pkg::POS_W-1:0] pos_y;
    logic signed [gmp_pkg::POS_W-1:0] pos_z;
    logic signed [gmp_pkg::POS_W-1:0] pos_e;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output pos_e, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input pos_e, output ready);
endinterface

// File: rtl/core/gcode_move_parser.sv
// gcode_move_parser: top level of the G0/G1 move parser.
// Depends on gmp_pkg, gmp_char_if, gmp_pos_if, gmp_in_reg, gmp_core,
// gmp_out_buf and assert_macros.svh.
//
//  channel | role | beat payload                           | rule
//  --------+------+----------------------------------------+----------------------------
//  chars   | in   | char_byte[7:0], end_of_file            | taken when valid & ready
//  moves   | out  | pos_x, pos_y, pos_z, pos_e (32b signed)| one beat per G0/G1 line
//
// One character per clock while chars is not stalled; gmp_core updates the
// parser state as each held character moves on. A line-ending character's
// position beat passes the input register, then the result buffer.
// Reset clears the parser to start of line and all positions to zero.
// The result buffer holds two beats; chars stalls only when it is full and
// the held character ends a move line.
`include "assert_macros.svh"

module gcode_move_parser (
    input  logic       clk,
    input  logic       rst_n,
    gmp_char_if.sink   chars,
    gmp_pos_if.source  moves
);

    gmp_pkg::held_t      held;
    gmp_pkg::pos_beat_t  core_result;
    logic                core_emit;
    logic                out_space;
    logic                advance;
    logic                push;

    // A held character moves on unless its result has nowhere to go
    assign advance = held.valid && (!core_emit || out_space);
    assign push    = advance && core_emit;

    gmp_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .advance (advance),
        .held    (held)
    );

    gmp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .beat   (held.beat),
        .emit   (core_emit),
        .result (core_result)
    );

    gmp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (core_result),
        .space     (out_space),
        .moves     (moves)
    );

    // Checks
    `GMP_ASSERT(a_emit_on_line_end, held.valid && core_emit |-> (held.beat.char_byte == gmp_pkg::CH_LF || held.beat.end_of_file), "result without line end")
    `GMP_ASSERT(a_stall_cause, !chars.ready |-> held.valid && core_emit && !out_space, "input stalled without a full result buffer")
    `GMP_ASSERT(a_push_shows, push |=> moves.valid, "pushed result not offered")
    `GMP_ASSERT_ALWAYS(a_full_offers, !out_space |-> moves.valid, "full buffer not offering")

endmodule

// File: rtl/core/gmp_in_reg.sv
// gmp_in_reg: input register of the move parser, one character beat deep.
// Depends on gmp_pkg and gmp_char_if.
module gmp_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    gmp_char_if.sink           chars,
    input  logic               advance,
    output gmp_pkg::held_t     held
);

    logic                 valid_reg;
    logic                 valid_next;
    gmp_pkg::char_beat_t  beat_reg;
    logic                 take;

    // Room whenever empty or the held character moves on this cycle
    assign chars.ready = !valid_reg || advance;
    assign take        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.char_byte   <= chars.char_byte;
            beat_reg.end_of_file <= chars.end_of_file;
        end
    end

    assign held.valid = valid_reg;
    assign held.beat  = beat_reg;

endmodule

// File: rtl/core/gmp_scale.sv
// gmp_scale: pads a parsed digit string to FRAC_DIGITS fraction digits,
// saturates and applies the sign. Depends on gmp_pkg.
module gmp_scale (
    input  logic [gmp_pkg::ACC_W-1:0] acc,
    input  logic [gmp_pkg::EXP_W-1:0] exp_sel,
    input  logic [3:0]                add_digit,
    input  logic                      negative,
    input  logic                      number_ok,
    output gmp_pkg::value_t           value
);

    localparam int PROD_W = gmp_pkg::ACC_W + gmp_pkg::MUL_W;

    logic [gmp_pkg::MUL_W-1:0]   mul;
    logic [gmp_pkg::MUL_W-1:0]   add_pow;
    logic [PROD_W-1:0]           prod;
    logic [gmp_pkg::MUL_W+3:0]   addend;
    logic [PROD_W:0]             sum;
    logic [gmp_pkg::ACC_W-1:0]   mag;

    // acc * 10^e + digit * 10^(e-1); digit is zero whenever e is zero
    assign mul     = gmp_pkg::pow10(exp_sel);
    assign add_pow = (exp_sel == '0) ? '0
                   : gmp_pkg::pow10(gmp_pkg::EXP_W'(exp_sel - 1'b1));
    assign prod    = PROD_W'(acc) * PROD_W'(mul);
    assign addend  = (gmp_pkg::MUL_W + 4)'(add_digit) * (gmp_pkg::MUL_W + 4)'(add_pow);
    assign sum     = (PROD_W + 1)'(prod) + (PROD_W + 1)'(addend);

    // Saturate the magnitude at the cap
    assign mag = (sum > (PROD_W + 1)'(gmp_pkg::MAG_CAP)) ? gmp_pkg::MAG_CAP
               : sum[gmp_pkg::ACC_W-1:0];

    always_comb
    begin
        if (!number_ok)
        begin
            value = '0;
        end
        else if (negative)
        begin
            value = gmp_pkg::value_t'(-mag);
        end
        else if (mag == gmp_pkg::MAG_CAP)
        begin
            value = gmp_pkg::value_t'(gmp_pkg::MAG_CAP - 1'b1);
        end
        else
        begin
            value = gmp_pkg::value_t'(mag);
        end
    end

endmodule

// File: rtl/core/gmp_core.sv
// gmp_core: per-character parser state update and position bookkeeping.
// Depends on gmp_pkg and gmp_scale.
module gmp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  gmp_pkg::char_beat_t  beat,
    output logic                 emit,
    output gmp_pkg::pos_beat_t   result
);

    // Line phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_ARG   = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    // Command match
    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_G    = 2'd1;
    localparam logic [1:0] CM_MOVE = 2'd2;
    localparam logic [1:0] CM_FAIL = 2'd3;

    typedef struct packed {
        logic point;
        logic bad;
        logic digit;
        logic sign;
    } num_flags_t;

    logic [2:0]                  phase_reg, ph_m, phase_next;
    logic [1:0]                  cm_reg, cm_m, cm_next;
    logic [2:0]                  axis_reg, ax_m, axis_next;
    logic [gmp_pkg::ACC_W-1:0]   acc_reg, acc_m, acc_next;
    logic                        neg_reg, neg_m, neg_next;
    logic [gmp_pkg::FRAC_W-1:0]  fc_reg, fc_m, fc_next;
    num_flags_t                  flags_reg, fl_m, flags_next;
    logic [3:0]                  seen_reg, seen_next;
    gmp_pkg::value_t             lv_reg [4];
    gmp_pkg::value_t             last_reg [4];
    gmp_pkg::value_t             lv_view [4];
    gmp_pkg::value_t             pos_view [4];

    logic [7:0]                  c;
    logic [7:0]                  cdiff;
    logic [3:0]                  dval;
    logic                        is_lf, is_ws, is_semi, is_other;
    logic                        is_digit, is_sign;
    logic                        tok_end, line_end;
    logic                        app;
    logic                        fin, lv_wr;

    logic [gmp_pkg::ACC_W-1:0]   digit_lim;
    logic [gmp_pkg::ACC_W+3:0]   acc_x10;
    logic [gmp_pkg::ACC_W-1:0]   acc_step;
    logic [gmp_pkg::EXP_W-1:0]   exp_sel;
    gmp_pkg::value_t             fin_value;

    // Character classes
    assign c        = beat.char_byte;
    assign cdiff    = c - gmp_pkg::CH_ZERO;
    assign dval     = cdiff[3:0];
    assign is_lf    = (c == gmp_pkg::CH_LF);
    assign is_ws    = (c == gmp_pkg::CH_SPACE) || (c == gmp_pkg::CH_TAB)
                   || (c == gmp_pkg::CH_CR) || (c == gmp_pkg::CH_VT)
                   || (c == gmp_pkg::CH_FF);
    assign is_semi  = (c == gmp_pkg::CH_SEMI);
    assign is_other = !(is_lf || is_ws || is_semi);
    assign is_digit = (c >= gmp_pkg::CH_ZERO) && (c <= gmp_pkg::CH_NINE);
    assign is_sign  = (c == gmp_pkg::CH_PLUS) || (c == gmp_pkg::CH_MINUS);
    assign line_end = is_lf || beat.end_of_file;
    assign tok_end  = !is_other || beat.end_of_file;

    // One decimal digit into the accumulator, saturating at the cap
    assign digit_lim = (dval <= gmp_pkg::CAP_MOD10) ? gmp_pkg::CAP_DIV10
                     : gmp_pkg::CAP_DIV10 - 1'b1;
    assign acc_x10   = {4'b0000, acc_reg} * (gmp_pkg::ACC_W + 4)'(10)
                     + (gmp_pkg::ACC_W + 4)'(dval);
    assign acc_step  = (acc_reg > digit_lim) ? gmp_pkg::MAG_CAP
                     : acc_x10[gmp_pkg::ACC_W-1:0];

    // Character processing for token characters
    always_comb
    begin
        ph_m  = phase_reg;
        cm_m  = cm_reg;
        ax_m  = axis_reg;
        acc_m = acc_reg;
        neg_m = neg_reg;
        fc_m  = fc_reg;
        fl_m  = flags_reg;
        app   = 1'b0;
        if (is_other)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    ph_m = PH_CMD;
                    cm_m = (c == gmp_pkg::CH_G) ? CM_G : CM_FAIL;
                end
                PH_CMD:
                begin
                    cm_m = (cm_reg == CM_G && (c == gmp_pkg::CH_ZERO || c == gmp_pkg::CH_ONE))
                         ? CM_MOVE : CM_FAIL;
                end
                PH_GAP:
                begin
                    ph_m  = PH_ARG;
                    acc_m = '0;
                    neg_m = 1'b0;
                    fc_m  = '0;
                    fl_m  = '0;
                    unique case (c)
                        gmp_pkg::CH_X: ax_m = gmp_pkg::AX_X;
                        gmp_pkg::CH_Y: ax_m = gmp_pkg::AX_Y;
                        gmp_pkg::CH_Z: ax_m = gmp_pkg::AX_Z;
                        gmp_pkg::CH_E: ax_m = gmp_pkg::AX_E;
                        default:       ax_m = gmp_pkg::AX_NONE;
                    endcase
                end
                PH_ARG:
                begin
                    if (axis_reg != gmp_pkg::AX_NONE)
                    begin
                        if (is_sign)
                        begin
                            if (flags_reg.digit || flags_reg.point || flags_reg.sign)
                            begin
                                fl_m.bad = 1'b1;
                            end
                            else
                            begin
                                fl_m.sign = 1'b1;
                                neg_m     = (c == gmp_pkg::CH_MINUS);
                            end
                        end
                        else if (is_digit)
                        begin
                            fl_m.digit = 1'b1;
                            if (!flags_reg.point)
                            begin
                                acc_m = acc_step;
                                app   = 1'b1;
                            end
                            else if (fc_reg < gmp_pkg::FRAC_W'(gmp_pkg::FRAC_DIGITS))
                            begin
                                acc_m = acc_step;
                                fc_m  = gmp_pkg::FRAC_W'(fc_reg + 1'b1);
                                app   = 1'b1;
                            end
                        end
                        else if (c == gmp_pkg::CH_POINT)
                        begin
                            if (flags_reg.point)
                            begin
                                fl_m.bad = 1'b1;
                            end
                            else
                            begin
                                fl_m.point = 1'b1;
                            end
                        end
                        else
                        begin
                            fl_m.bad = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Padding exponent; a digit taken this cycle rides along as an addend
    assign exp_sel = gmp_pkg::EXP_W'(gmp_pkg::EXP_W'(gmp_pkg::FRAC_DIGITS)
                   - gmp_pkg::EXP_W'(fc_reg)
                   + gmp_pkg::EXP_W'(app && !flags_reg.point));

    gmp_scale u_scale (
        .acc       (acc_reg),
        .exp_sel   (exp_sel),
        .add_digit (app ? dval : 4'd0),
        .negative  (neg_m),
        .number_ok (!fl_m.bad && fl_m.digit),
        .value     (fin_value)
    );

    // Token end, line end and result selection
    always_comb
    begin
        phase_next = ph_m;
        cm_next    = cm_m;
        axis_next  = ax_m;
        acc_next   = acc_m;
        neg_next   = neg_m;
        fc_next    = fc_m;
        flags_next = fl_m;
        fin        = 1'b0;
        seen_next  = seen_reg;
        if (tok_end)
        begin
            if (ph_m == PH_CMD)
            begin
                if (cm_m == CM_MOVE)
                begin
                    phase_next = PH_GAP;
                end
                else
                begin
                    cm_next    = CM_FAIL;
                    phase_next = PH_SKIP;
                end
            end
            else if (ph_m == PH_ARG)
            begin
                fin        = 1'b1;
                phase_next = PH_GAP;
                axis_next  = gmp_pkg::AX_NONE;
                acc_next   = '0;
                neg_next   = 1'b0;
                fc_next    = '0;
                flags_next = '0;
            end
            if (is_semi)
            begin
                phase_next = PH_SKIP;
            end
        end

        lv_wr = fin && (ax_m != gmp_pkg::AX_NONE);
        if (lv_wr)
        begin
            seen_next[ax_m[1:0]] = 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            lv_view[i]  = (lv_wr && ax_m[1:0] == 2'(i)) ? fin_value : lv_reg[i];
            pos_view[i] = seen_next[i] ? lv_view[i] : last_reg[i];
        end

        emit = line_end && (cm_next == CM_MOVE);

        if (line_end)
        begin
            phase_next = PH_START;
            cm_next    = CM_NONE;
            axis_next  = gmp_pkg::AX_NONE;
            acc_next   = '0;
            neg_next   = 1'b0;
            fc_next    = '0;
            flags_next = '0;
            seen_next  = '0;
        end
    end

    assign result.pos_x = gmp_pkg::to_pos(pos_view[0]);
    assign result.pos_y = gmp_pkg::to_pos(pos_view[1]);
    assign result.pos_z = gmp_pkg::to_pos(pos_view[2]);
    assign result.pos_e = gmp_pkg::to_pos(pos_view[3]);

    // Parser state and last emitted position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cm_reg    <= CM_NONE;
            axis_reg  <= gmp_pkg::AX_NONE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            fc_reg    <= '0;
            flags_reg <= '0;
            seen_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cm_reg    <= cm_next;
            axis_reg  <= axis_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            fc_reg    <= fc_next;
            flags_reg <= flags_next;
            seen_reg  <= seen_next;
            if (emit)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    last_reg[i] <= pos_view[i];
                end
            end
        end
    end

    // Per-line axis values, read only behind their seen bits
    always_ff @(posedge clk)
    begin
        if (fire && lv_wr)
        begin
            lv_reg[ax_m[1:0]] <= fin_value;
        end
    end

endmodule

// File: rtl/core/gmp_out_buf.sv
// gmp_out_buf: two-entry result buffer that parts the parser from the
// position sink. Depends on gmp_pkg and gmp_pos_if.
module gmp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gmp_pkg::pos_beat_t push_beat,
    output logic               space,
    gmp_pos_if.source          moves
);

    gmp_pkg::pos_beat_t slot_reg [2];
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               pop;
    logic               wr_second;

    assign pop       = moves.valid && moves.ready;
    assign space     = (count_reg != 2'd2);
    assign wr_second = (count_reg == 2'd1) && !pop;

    assign count_next = 2'(count_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Head shifts on a pop; a push lands behind whatever stays
    always_ff @(posedge clk)
    begin
        if (push && !wr_second)
        begin
            slot_reg[0] <= push_beat;
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
        end
        if (push && wr_second)
        begin
            slot_reg[1] <= push_beat;
        end
    end

    assign moves.valid = (count_reg != 2'd0);
    assign moves.pos_x = slot_reg[0].pos_x;
    assign moves.pos_y = slot_reg[0].pos_y;
    assign moves.pos_z = slot_reg[0].pos_z;
    assign moves.pos_e = slot_reg[0].pos_e;

endmodule

// File: test/tb.sv
// tb.sv: self-checking bench for gcode_move_parser, the G0/G1 move parser.
// Depends on gmp_pkg, gmp_char_if, gmp_pos_if and the parser RTL; reads no files.
// Character beats go in, an in-bench parser predicts every position beat out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gmp_pkg::*;

    // Parser state of the in-bench prediction
    typedef enum logic [2:0] {
        AT_LINE_START,
        IN_COMMAND,
        BETWEEN_ARGS,
        IN_ARGUMENT,
        SKIP_TO_EOL
    } line_phase_e;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_G_SEEN,
        CMD_MOVE,
        CMD_REJECTED
    } cmd_state_e;

    // How a generated line is terminated
    typedef enum logic [1:0] {
        END_LF,
        END_ON_LAST,
        END_LF_EOF
    } line_end_e;

    localparam logic [63:0] MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);
    localparam int          LONG_HOLD = 150;
    localparam int          RANDOM_CHARS = 320;
    localparam int          MIN_MOVES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side drive registers, known from time zero
    logic       char_valid = 1'b0;
    logic [7:0] char_code = '0;
    logic       char_eof = 1'b0;
    logic       move_ready = 1'b0;

    gmp_char_if chars();
    gmp_pos_if  moves();

    assign chars.valid       = char_valid;
    assign chars.char_byte   = char_code;
    assign chars.end_of_file = char_eof;
    assign moves.ready       = move_ready;

    gcode_move_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .moves (moves)
    );

    // Stimulus and scoreboard storage
    char_beat_t  char_beats [$];
    logic [7:0]  line_buf [$];
    pos_beat_t   expected_moves [$];
    int          moves_planned = 0;
    int          mismatches = 0;
    int          moves_taken = 0;
    int          send_wait = 0;
    bit          send_calm = 1'b0;
    int          recv_wait = 0;
    bit          recv_calm = 1'b0;
    string       other_cmds [6] = '{"G2", "G01", "g0", "M82", "T0", "G1X3"};

    // Predicted parser state, starting at its reset values
    line_phase_e phase_now = AT_LINE_START;
    cmd_state_e  cmd_now = CMD_NONE;
    logic [2:0]  arg_axis = AX_NONE;
    logic [63:0] num_mag = '0;
    logic        num_neg = 1'b0;
    logic        has_point = 1'b0;
    logic        is_bad = 1'b0;
    logic        has_digit = 1'b0;
    logic        has_sign = 1'b0;
    int          frac_seen = 0;
    logic [63:0] line_vals [4] = '{default: '0};
    logic [3:0]  line_seen = '0;
    logic [63:0] last_pos [4] = '{default: '0};

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Move position prediction
    // ---------------------------------------------------------------

    // Append one decimal digit, pinning the magnitude at the cap
    function automatic void push_digit(logic [3:0] d);
        if (num_mag > (MAG_LIMIT - 64'(d)) / 10)
            num_mag = MAG_LIMIT;
        else
            num_mag = num_mag * 10 + 64'(d);
    endfunction

    function automatic void clear_number();
        num_mag   = '0;
        num_neg   = 1'b0;
        frac_seen = 0;
        has_point = 1'b0;
        is_bad    = 1'b0;
        has_digit = 1'b0;
        has_sign  = 1'b0;
    endfunction

    // Close an argument token: pad the fraction, clamp, latch the axis value
    function automatic void finish_axis_value();
        logic [63:0] v;
        v = '0;
        if (arg_axis != AX_NONE)
        begin
            if (!is_bad && has_digit)
            begin
                while (frac_seen < FRAC_DIGITS)
                begin
                    push_digit(4'd0);
                    frac_seen++;
                end
                if (num_neg)
                begin
                    v = (num_mag > MAG_LIMIT) ? MAG_LIMIT : num_mag;
                    v = 64'd0 - v;
                end
                else
                begin
                    v = (num_mag > MAG_LIMIT - 1) ? MAG_LIMIT - 1 : num_mag;
                end
            end
            line_vals[arg_axis] = v;
            line_seen[arg_axis] = 1'b1;
        end
        arg_axis = AX_NONE;
        clear_number();
    endfunction

    function automatic void close_token();
        if (phase_now == IN_COMMAND)
        begin
            if (cmd_now == CMD_MOVE)
            begin
                phase_now = BETWEEN_ARGS;
            end
            else
            begin
                cmd_now   = CMD_REJECTED;
                phase_now = SKIP_TO_EOL;
            end
        end
        else if (phase_now == IN_ARGUMENT)
        begin
            finish_axis_value();
            phase_now = BETWEEN_ARGS;
        end
    endfunction

    // Number syntax inside an axis argument
    function automatic void number_char(logic [7:0] c);
        if (arg_axis == AX_NONE)
            return;
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            if (has_digit || has_point || has_sign)
            begin
                is_bad = 1'b1;
            end
            else
            begin
                has_sign = 1'b1;
                num_neg  = (c == CH_MINUS);
            end
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            has_digit = 1'b1;
            if (!has_point)
            begin
                push_digit(4'(c - CH_ZERO));
            end
            else if (frac_seen < FRAC_DIGITS)
            begin
                push_digit(4'(c - CH_ZERO));
                frac_seen++;
            end
        end
        else if (c == CH_POINT)
        begin
            if (has_point)
                is_bad = 1'b1;
            else
                has_point = 1'b1;
        end
        else
        begin
            is_bad = 1'b1;
        end
    endfunction

    // End of line: a move line queues the updated positions
    function automatic void close_line();
        pos_beat_t beat;
        close_token();
        if (cmd_now == CMD_MOVE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (line_seen[i])
                    last_pos[i] = line_vals[i];
            end
            beat.pos_x = last_pos[AX_X][POS_W-1:0];
            beat.pos_y = last_pos[AX_Y][POS_W-1:0];
            beat.pos_z = last_pos[AX_Z][POS_W-1:0];
            beat.pos_e = last_pos[AX_E][POS_W-1:0];
            expected_moves.push_back(beat);
        end
        phase_now = AT_LINE_START;
        cmd_now   = CMD_NONE;
        arg_axis  = AX_NONE;
        clear_number();
        line_vals = '{default: '0};
        line_seen = '0;
    endfunction

    // One accepted character beat
    function automatic void parse_char(logic [7:0] c, logic eof);
        if (c == CH_LF)
        begin
            close_line();
            return;
        end
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF)
        begin
            close_token();
        end
        else if (c == CH_SEMI)
        begin
            close_token();
            phase_now = SKIP_TO_EOL;
        end
        else
        begin
            case (phase_now)
                AT_LINE_START:
                begin
                    phase_now = IN_COMMAND;
                    cmd_now   = (c == CH_G) ? CMD_G_SEEN : CMD_REJECTED;
                end
                IN_COMMAND:
                begin
                    if (cmd_now == CMD_G_SEEN && (c == CH_ZERO || c == CH_ONE))
                        cmd_now = CMD_MOVE;
                    else
                        cmd_now = CMD_REJECTED;
                end
                BETWEEN_ARGS:
                begin
                    phase_now = IN_ARGUMENT;
                    clear_number();
                    case (c)
                        CH_X:    arg_axis = AX_X;
                        CH_Y:    arg_axis = AX_Y;
                        CH_Z:    arg_axis = AX_Z;
                        CH_E:    arg_axis = AX_E;
                        default: arg_axis = AX_NONE;
                    endcase
                end
                IN_ARGUMENT:
                begin
                    number_char(c);
                end
                default:
                begin
                end
            endcase
        end
        if (eof)
            close_line();
    endfunction

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------

    function automatic void put_byte(logic [7:0] b);
        line_buf.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_digit();
        put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // Token separator: mostly spaces, sometimes the other blank characters
    function automatic void put_gap();
        int n;
        n = $urandom_range(1, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0:       put_byte(CH_TAB);
                1:       put_byte(CH_CR);
                2:       put_byte(CH_VT);
                3:       put_byte(CH_FF);
                default: put_byte(CH_SPACE);
            endcase
        end
    endfunction

    // Signed decimal, sometimes long enough to saturate, sometimes malformed
    function automatic void put_number();
        int    pick;
        int    n_int;
        int    n_frac;
        string junk;
        junk = "e+-.i";
        pick = $urandom_range(0, 5);
        if (pick == 0)
            put_byte(CH_MINUS);
        else if (pick == 1)
            put_byte(CH_PLUS);
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
        repeat (n_int) put_digit();
        if ($urandom_range(0, 1) == 1)
        begin
            put_byte(CH_POINT);
            n_frac = $urandom_range(0, 5);
            repeat (n_frac) put_digit();
        end
        if ($urandom_range(0, 11) == 0)
            put_byte(junk[$urandom_range(0, 4)]);
    endfunction

    function automatic void put_arg();
        case ($urandom_range(0, 11))
            0, 1:    put_byte(CH_X);
            2, 3:    put_byte(CH_Y);
            4, 5:    put_byte(CH_Z);
            6, 7:    put_byte(CH_E);
            8:       put_text("F");
            9:       put_text("x");
            10:      put_text("S");
            default: put_byte(8'($urandom_range(33, 255)));
        endcase
        if ($urandom_range(0, 11) != 0)
            put_number();
    endfunction

    function automatic void put_comment();
        int n;
        put_byte(CH_SEMI);
        n = $urandom_range(0, 8);
        repeat (n) put_byte(8'($urandom_range(32, 126)));
    endfunction

    // Move the buffered line into the beat queue with the chosen terminator
    function automatic void end_line_with(line_end_e how);
        char_beat_t b;
        if (how == END_ON_LAST && line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        foreach (line_buf[i])
        begin
            b.char_byte   = line_buf[i];
            b.end_of_file = (how == END_ON_LAST) && (i == line_buf.size() - 1);
            char_beats.push_back(b);
        end
        if (how != END_ON_LAST)
        begin
            b.char_byte   = CH_LF;
            b.end_of_file = (how == END_LF_EOF);
            char_beats.push_back(b);
        end
        line_buf.delete();
    endfunction

    // Mostly well-formed move lines, then other commands, blanks and noise
    function automatic void add_random_line();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n    = $urandom_range(0, 5);
        if (pick < 70)
        begin
            if ($urandom_range(0, 4) == 0)
                put_gap();
            put_text(($urandom_range(0, 1) == 1) ? "G1" : "G0");
            repeat (n)
            begin
                put_gap();
                put_arg();
            end
            if ($urandom_range(0, 4) == 0)
                put_comment();
            moves_planned++;
        end
        else if (pick < 80)
        begin
            put_text(other_cmds[$urandom_range(0, 5)]);
            repeat (n)
            begin
                put_gap();
                put_arg();
            end
        end
        else if (pick < 88)
        begin
            if (pick < 83)
                put_comment();
            else if (pick < 86)
                put_gap();
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                put_text("G1 X");
            n = $urandom_range(1, 12);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            end_line_with(END_ON_LAST);
        else if (pick == 1)
            end_line_with(END_LF_EOF);
        else
            end_line_with(END_LF);
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_axis(string axis_name, logic signed [31:0] got,
                              logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", axis_name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Character driver: one queued beat at a time, random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        char_beat_t next_beat;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_code  <= '0;
            char_eof   <= 1'b0;
        end
        else
        begin
            if (char_valid && chars.ready)
                parse_char(char_code, char_eof);
            // Bus is free unless a beat is still waiting for ready
            if (!char_valid || chars.ready)
            begin
                if (char_beats.size() != 0 && send_wait == 0)
                begin
                    next_beat  = char_beats.pop_front();
                    char_valid <= 1'b1;
                    char_code  <= next_beat.char_byte;
                    char_eof   <= next_beat.end_of_file;
                    send_wait  = send_calm ? 0 : $urandom_range(0, 6);
                    if ($urandom_range(0, 60) == 0)
                        send_calm = !send_calm;
                end
                else
                begin
                    char_valid <= 1'b0;
                    if (send_wait != 0)
                        send_wait--;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Move receiver: random stalls, two long hold-offs to fill the block
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_ready <= 1'b0;
        end
        else
        begin
            if (moves.valid && move_ready)
            begin
                moves_taken++;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
                if (moves_taken == 12 || moves_taken == 20)
                    recv_wait = LONG_HOLD;
                if ($urandom_range(0, 20) == 0)
                    recv_calm = !recv_calm;
            end
            if (recv_wait != 0)
            begin
                recv_wait--;
                move_ready <= 1'b0;
            end
            else
            begin
                move_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Move monitor: compare each accepted beat with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_moves
        pos_beat_t want;
        if (rst_n && moves.valid && moves.ready)
        begin
            if (expected_moves.size() == 0)
            begin
                report_mismatch($sformatf("move beat with none expected: %0d %0d %0d %0d",
                                          moves.pos_x, moves.pos_y, moves.pos_z,
                                          moves.pos_e));
            end
            else
            begin
                want = expected_moves.pop_front();
                check_axis("pos_x", moves.pos_x, want.pos_x);
                check_axis("pos_y", moves.pos_y, want.pos_y);
                check_axis("pos_z", moves.pos_z, want.pos_z);
                check_axis("pos_e", moves.pos_e, want.pos_e);
            end
        end
    end

    // Reset: held low from time zero, released once
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int directed_len;

        // Plain move with fraction truncation and signs
        put_text("G1 X12.5 Y-3 Z0.0004 E+7.25");
        end_line_with(END_LF);
        // Exact range extremes
        put_text("G0 X2147483.647 Y-2147483.648");
        end_line_with(END_LF);
        // Saturation both ways, tiny negative fraction
        put_text("G0 X2147483.648 Y-2147483.649 Z99999999999 E-.0001");
        end_line_with(END_LF);
        // No axis: last positions repeat
        put_text("G1 F1500");
        end_line_with(END_LF);
        // Not moves: exact, case-sensitive match only
        put_text("G00 X1");
        end_line_with(END_LF);
        put_text("g1 X1");
        end_line_with(END_LF);
        put_text("G1X5");
        end_line_with(END_LF);
        put_text("M104 S200");
        end_line_with(END_LF);
        put_text("G");
        end_line_with(END_LF);
        // Empty, comment-only and blank lines
        end_line_with(END_LF);
        put_text("; only a comment");
        end_line_with(END_LF);
        put_byte(CH_SPACE);
        put_byte(CH_TAB);
        put_byte(CH_CR);
        put_byte(CH_VT);
        put_byte(CH_FF);
        end_line_with(END_LF);
        // Malformed numbers and a lone axis letter read as zero
        put_text("G1 X1e3 Y1..2 Z+-1 E");
        end_line_with(END_LF);
        // Repeated axis, ignored tokens, lowercase letter
        put_text("G1 X5 Q9 x3 X7 Y4 Yinf");
        end_line_with(END_LF);
        // Leading blanks, bare fractions, negative zero
        put_text("  G1 Y.5 Z5. E-0 X-0.0009999");
        end_line_with(END_LF);
        // Tab, CR, VT and FF as separators
        put_text("G1");
        put_byte(CH_TAB);
        put_text("X1");
        put_byte(CH_CR);
        put_text("Y2");
        put_byte(CH_VT);
        put_text("Z3");
        put_byte(CH_FF);
        put_text("E4");
        end_line_with(END_LF);
        // Comments cut the rest of the line
        put_text("G1 X3;X9 Y9");
        end_line_with(END_LF);
        put_text("G1 Z8 ;comment");
        end_line_with(END_LF);
        // NUL and high bytes are token characters
        put_text("G1 X");
        put_byte(8'h00);
        put_text(" Y1");
        put_byte(8'hFF);
        put_byte(CH_SPACE);
        put_byte(8'h80);
        put_text("Z2 E");
        put_byte(8'h7F);
        end_line_with(END_LF);
        // End of file on a digit, on LF, on a blank and inside a comment
        put_text("G0 X4");
        end_line_with(END_ON_LAST);
        put_text("G1 Y5");
        end_line_with(END_LF_EOF);
        put_text("G1 Z6 ");
        end_line_with(END_ON_LAST);
        put_text("G1 E7 ;c");
        end_line_with(END_ON_LAST);
        end_line_with(END_ON_LAST);

        // Random part
        directed_len = char_beats.size();
        while (char_beats.size() < directed_len + RANDOM_CHARS || moves_planned < MIN_MOVES)
            add_random_line();

        // Drain: all beats sent, all predictions met, then a short settle
        do
            @(posedge clk);
        while (char_beats.size() != 0 || char_valid);
        while (expected_moves.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
